FILE: design/assert_macros.svh
// Assertion macros shared by the sweep core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is held.
`define BBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Clocked check that also holds during reset.
`define BBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);
`else
`define BBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/bbs_pkg.sv
// Shared types, constants and helpers of the backward sweep core.
package bbs_pkg;

    localparam int STATE_W  = 10;
    localparam int INPUT_W  = 4;
    localparam int STAGE_W  = 6;
    localparam int COST_W   = 32;
    localparam int NS_W     = STATE_W + 1;
    localparam int NU_W     = INPUT_W + 1;

    localparam int MAX_STATES = 2 ** STATE_W;
    localparam int MAX_INPUTS = 2 ** INPUT_W;
    localparam int MAX_STAGES = 2 ** STAGE_W;

    localparam int COST_ADDR_W  = STATE_W + 1;
    localparam int TRANS_ADDR_W = INPUT_W + STATE_W;
    localparam int POL_ADDR_W   = STAGE_W + STATE_W;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_DATA_W = NS_W;

    typedef logic [COST_W-1:0] t_cost;

    localparam t_cost COST_INF = '1;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        KIND_TERM   = 2'd0,
        KIND_TRANS  = 2'd1,
        KIND_BACKUP = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    // Configuration register indexes
    typedef enum logic {
        CFG_STATES = 1'b0,
        CFG_INPUTS = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SWEEP,
        ST_QREAD,
        ST_QRESP,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_kind                kind;
        logic [STATE_W-1:0]   state_idx;
        logic [INPUT_W-1:0]   input_idx;
        logic [STATE_W-1:0]   next_state;
        t_cost                cost;
        logic [STAGE_W-1:0]   stage;
    } t_item;

    typedef struct packed {
        logic [STATE_W-1:0] next;
        t_cost              cost;
    } t_trans;

    typedef struct packed {
        logic [STATE_W-1:0] next;
        logic [INPUT_W-1:0] inp;
    } t_policy;

    typedef struct packed {
        logic                   en;
        logic [COST_ADDR_W-1:0] addr;
        t_cost                  data;
    } t_cost_wr;

    typedef struct packed {
        logic                    en;
        logic [TRANS_ADDR_W-1:0] addr;
        t_trans                  data;
    } t_trans_wr;

    typedef struct packed {
        logic                  en;
        logic [POL_ADDR_W-1:0] addr;
        t_policy               data;
    } t_pol_wr;

    // Saturating cost add: infinity in, or a sum reaching all ones, gives infinity
    function automatic t_cost sat_add(input t_cost a, input t_cost b);
        logic [COST_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum >= {1'b0, COST_INF}) ? COST_INF : sum[COST_W-1:0];
    endfunction

endpackage

FILE: design/bbs_store.sv
// Cost banks, transition table and policy table memories.
module bbs_store
    import bbs_pkg::*;
(
    input  logic                    i_clk,
    // cost banks: one write, two reads
    input  t_cost_wr                i_cost_wr,
    input  logic [COST_ADDR_W-1:0]  i_cost_rd_addr_a,
    input  logic [COST_ADDR_W-1:0]  i_cost_rd_addr_b,
    output t_cost                   o_cost_rd_a,
    output t_cost                   o_cost_rd_b,
    // transition table
    input  t_trans_wr               i_trans_wr,
    input  logic [TRANS_ADDR_W-1:0] i_trans_rd_addr,
    output t_trans                  o_trans_rd,
    // policy table
    input  t_pol_wr                 i_pol_wr,
    input  logic [POL_ADDR_W-1:0]   i_pol_rd_addr,
    output t_policy                 o_pol_rd
);

    t_cost   r_cost_mem  [2**COST_ADDR_W];
    t_trans  r_trans_mem [2**TRANS_ADDR_W];
    t_policy r_pol_mem   [2**POL_ADDR_W];

    t_cost   r_cost_rd_a;
    t_cost   r_cost_rd_b;
    t_trans  r_trans_rd;
    t_policy r_pol_rd;

    // cost banks
    always_ff @(posedge i_clk) begin
        if (i_cost_wr.en) begin
            r_cost_mem[i_cost_wr.addr] <= i_cost_wr.data;
        end
        r_cost_rd_a <= r_cost_mem[i_cost_rd_addr_a];
        r_cost_rd_b <= r_cost_mem[i_cost_rd_addr_b];
    end

    // transition table
    always_ff @(posedge i_clk) begin
        if (i_trans_wr.en) begin
            r_trans_mem[i_trans_wr.addr] <= i_trans_wr.data;
        end
        r_trans_rd <= r_trans_mem[i_trans_rd_addr];
    end

    // policy table
    always_ff @(posedge i_clk) begin
        if (i_pol_wr.en) begin
            r_pol_mem[i_pol_wr.addr] <= i_pol_wr.data;
        end
        r_pol_rd <= r_pol_mem[i_pol_rd_addr];
    end

    assign o_cost_rd_a = r_cost_rd_a;
    assign o_cost_rd_b = r_cost_rd_b;
    assign o_trans_rd  = r_trans_rd;
    assign o_pol_rd    = r_pol_rd;

endmodule

FILE: design/bbs_sweep.sv
// Backup stage sequencer: issues (state, input) reads and folds the minimum per state.
`include "assert_macros.svh"
module bbs_sweep
    import bbs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_bank,
    input  logic [NS_W-1:0]         i_ns,
    input  logic [NU_W-1:0]         i_nu,
    input  logic [STAGE_W-1:0]      i_stage,
    input  logic                    i_stage_seen,
    input  t_trans                  i_trans_rd,
    input  t_cost                   i_cost_rd_a,
    input  t_cost                   i_cost_rd_b,
    output logic [TRANS_ADDR_W-1:0] o_trans_rd_addr,
    output logic [COST_ADDR_W-1:0]  o_cost_rd_addr_a,
    output logic [COST_ADDR_W-1:0]  o_cost_rd_addr_b,
    output t_cost_wr                o_cost_wr,
    output t_pol_wr                 o_pol_wr,
    output logic                    o_busy,
    output logic                    o_done
);

    typedef struct packed {
        logic [STATE_W-1:0] s;
        logic [INPUT_W-1:0] u;
        logic               first;
        logic               last;
        logic               skip;
        logic               beyond;
    } t_p1;

    typedef struct packed {
        logic [STATE_W-1:0] s;
        logic [INPUT_W-1:0] u;
        logic               first;
        logic               last;
        logic               beyond;
        logic               cand_ok;
        logic [STATE_W-1:0] nx;
        t_cost              tcost;
        t_cost              old_s;
    } t_p2;

    typedef struct packed {
        logic [STATE_W-1:0] s;
        logic [INPUT_W-1:0] u;
        logic               first;
        logic               last;
        logic               beyond;
        logic               cand_ok;
        logic [STATE_W-1:0] nx;
        t_cost              cand;
        t_cost              old_s;
    } t_p3;

    typedef struct packed {
        logic [STATE_W-1:0] s;
        logic               beyond;
        logic               found;
        t_cost              best;
        logic [STATE_W-1:0] bnext;
        logic [INPUT_W-1:0] binput;
        t_cost              old_s;
    } t_p4;

    // latched per backup
    logic               r_bank;
    logic [NS_W-1:0]    r_ns;
    logic [NU_W-1:0]    r_nu;
    logic [STAGE_W-1:0] r_stage;
    logic               r_seen;

    // issue counters
    logic               r_run;
    logic [STATE_W-1:0] r_s;
    logic [INPUT_W-1:0] r_u;

    logic r_p1_valid, r_p2_valid, r_p3_valid, r_p4_valid;
    t_p1  r_p1;
    t_p2  r_p2;
    t_p3  r_p3;
    t_p4  r_p4;

    // running minimum of the state in stage 3
    logic               r_found;
    t_cost              r_best;
    logic [STATE_W-1:0] r_bnext;
    logic [INPUT_W-1:0] r_binput;

    logic               w_beyond;
    logic               w_skip;
    logic               w_last;
    logic               w_cand_ok;
    t_cost              w_base_best;
    logic               w_base_found;
    logic [STATE_W-1:0] w_base_bnext;
    logic [INPUT_W-1:0] w_base_binput;
    logic               w_take;
    logic               n_found;
    t_cost              n_best;
    logic [STATE_W-1:0] n_bnext;
    logic [INPUT_W-1:0] n_binput;
    logic [NS_W-1:0]    w_ns_clamp;
    logic [NU_W-1:0]    w_nu_clamp;

    // register counts above the maximum saturate
    assign w_ns_clamp = (i_ns > NS_W'(MAX_STATES)) ? NS_W'(MAX_STATES) : i_ns;
    assign w_nu_clamp = (i_nu > NU_W'(MAX_INPUTS)) ? NU_W'(MAX_INPUTS) : i_nu;

    // issue stage: one (state, input) pair per cycle, one slot for a state with no inputs
    assign w_beyond = ({1'b0, r_s} >= r_ns);
    assign w_skip   = w_beyond || (r_nu == '0);
    assign w_last   = w_skip || ({1'b0, r_u} == (r_nu - NU_W'(1)));

    assign o_trans_rd_addr  = {r_u, r_s};
    assign o_cost_rd_addr_b = {r_bank, r_s};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_s   <= '0;
            r_u   <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_s   <= '0;
            r_u   <= '0;
        end else if (r_run) begin
            if (w_last) begin
                r_u <= '0;
                if (r_s == '1) begin
                    r_run <= 1'b0;
                end else begin
                    r_s <= r_s + STATE_W'(1);
                end
            end else begin
                r_u <= r_u + INPUT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bank  <= i_bank;
            r_ns    <= w_ns_clamp;
            r_nu    <= w_nu_clamp;
            r_stage <= i_stage;
            r_seen  <= i_stage_seen;
        end
    end

    // stage 1: transition entry and old cost of the state arrive
    assign w_cand_ok        = !r_p1.skip && ({1'b0, i_trans_rd.next} < r_ns);
    assign o_cost_rd_addr_a = {r_bank, i_trans_rd.next};

    // stage 3: strict less-than keeps the first input on ties
    always_comb begin
        w_base_best   = r_p3.first ? COST_INF : r_best;
        w_base_found  = r_p3.first ? 1'b0 : r_found;
        w_base_bnext  = r_p3.first ? '0 : r_bnext;
        w_base_binput = r_p3.first ? '0 : r_binput;
        w_take        = r_p3.cand_ok && (r_p3.cand < w_base_best);
        n_best        = w_take ? r_p3.cand : w_base_best;
        n_found       = w_take || w_base_found;
        n_bnext       = w_take ? r_p3.nx : w_base_bnext;
        n_binput      = w_take ? r_p3.u : w_base_binput;
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else begin
            r_p1_valid <= r_run;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid && r_p3.last;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_p1.s      <= r_s;
        r_p1.u      <= r_u;
        r_p1.first  <= (r_u == '0);
        r_p1.last   <= w_last;
        r_p1.skip   <= w_skip;
        r_p1.beyond <= w_beyond;

        r_p2.s       <= r_p1.s;
        r_p2.u       <= r_p1.u;
        r_p2.first   <= r_p1.first;
        r_p2.last    <= r_p1.last;
        r_p2.beyond  <= r_p1.beyond;
        r_p2.cand_ok <= w_cand_ok;
        r_p2.nx      <= i_trans_rd.next;
        r_p2.tcost   <= i_trans_rd.cost;
        r_p2.old_s   <= i_cost_rd_b;

        r_p3.s       <= r_p2.s;
        r_p3.u       <= r_p2.u;
        r_p3.first   <= r_p2.first;
        r_p3.last    <= r_p2.last;
        r_p3.beyond  <= r_p2.beyond;
        r_p3.cand_ok <= r_p2.cand_ok;
        r_p3.nx      <= r_p2.nx;
        r_p3.cand    <= sat_add(r_p2.tcost, i_cost_rd_a);
        r_p3.old_s   <= r_p2.old_s;

        if (r_p3_valid) begin
            r_best   <= n_best;
            r_found  <= n_found;
            r_bnext  <= n_bnext;
            r_binput <= n_binput;
        end

        r_p4.s      <= r_p3.s;
        r_p4.beyond <= r_p3.beyond;
        r_p4.found  <= n_found;
        r_p4.best   <= n_best;
        r_p4.bnext  <= n_bnext;
        r_p4.binput <= n_binput;
        r_p4.old_s  <= r_p3.old_s;
    end

    // write-back into the other bank; reads and writes never share a bank
    always_comb begin
        o_cost_wr.en   = r_p4_valid;
        o_cost_wr.addr = {~r_bank, r_p4.s};
        o_cost_wr.data = r_p4.found ? r_p4.best : r_p4.old_s;

        // states beyond use keep their entries, unless the stage was never written
        o_pol_wr.en          = r_p4_valid && (!r_p4.beyond || !r_seen);
        o_pol_wr.addr        = {r_stage, r_p4.s};
        o_pol_wr.data.next   = r_p4.found ? r_p4.bnext : '0;
        o_pol_wr.data.inp    = r_p4.found ? r_p4.binput : '0;
    end

    assign o_done = r_p4_valid && (r_p4.s == '1);
    assign o_busy = r_run || r_p1_valid || r_p2_valid || r_p3_valid || r_p4_valid;

    `BBS_ASSERT(a_wr_other_bank, i_clk, i_rst_n, o_cost_wr.en |-> (o_cost_wr.addr[COST_ADDR_W-1] != r_bank), "sweep writes the bank it reads")
    `BBS_ASSERT(a_start_idle, i_clk, i_rst_n, i_start |-> !o_busy, "backup started while sweep busy")
    `BBS_ASSERT(a_fold_same_state, i_clk, i_rst_n, (r_p3_valid && !r_p3.first) |-> ($past(r_p3_valid) && (r_p3.s == $past(r_p3.s))), "minimum folds across states")

endmodule

FILE: design/tabled_bellman_backward_sweep_core.sv
// Top level of the tabled backward Bellman sweep engine.
//
// Input stream (s_axis): one beat per item, tuser selects the kind: load
// terminal cost, load transition, run one backup stage, or query a state.
// Output stream (m_axis): exactly one result beat per item; tuser is the
// done flag (1 after a load or backup, 0 after a query).
// Configuration: i_cfg_wr_en writes register i_cfg_index (0 states in use,
// 1 inputs in use) from i_cfg_wdata. Items are handled one at a time: a load
// passes through the load and response states, a query through the query-read
// and query-response states; then the block is idle for the next beat.
// A backup streams one (state, input) pair per cycle through the transition
// table and the cost bank read ports, covering each input in use of every
// state in use and every state beyond use, then drains its pipeline.
// The next item is taken while a finished result waits in the output
// register; if the receiver stalls, the block holds in its response state
// until the beat is taken.
// After reset all 2048 cost bank entries are swept to infinity, one entry per
// cycle, before the first item is accepted; configuration writes are
// taken during that pass. Policy entries of a never-written stage read zero.
`include "assert_macros.svh"
module tabled_bellman_backward_sweep_core
    import bbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: state_index[9:0], input_index[13:10], next_state[23:14],
    //        cost_value[55:24], stage[61:56], zero pad [63:62]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]            i_s_axis_tuser,
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: cost[31:0], best_next[41:32], best_input[45:42],
    //        is_infinite[46], zero pad [47]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: done_res[0]
    output logic                  o_m_axis_tuser,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_state                 r_state, n_state;
    t_item                  r_item;
    logic [NS_W-1:0]        r_states_use;
    logic [NU_W-1:0]        r_inputs_use;
    logic                   r_bank;
    logic [MAX_STAGES-1:0]  r_stage_seen;
    logic [COST_ADDR_W-1:0] r_clr;
    logic                   r_start;
    logic                   r_m_valid;
    logic [OUT_DATA_W-1:0]  r_m_data;
    logic                   r_m_user;

    logic                   w_accept;
    logic                   w_slot_free;
    logic                   w_res_load;
    t_item                  w_in_item;

    // sweep and memory wiring
    t_cost_wr                w_cost_wr;
    t_trans_wr               w_trans_wr;
    logic [COST_ADDR_W-1:0]  w_cost_rd_addr_a;
    t_cost                   w_cost_rd_a;
    t_cost                   w_cost_rd_b;
    t_trans                  w_trans_rd;
    t_policy                 w_pol_rd;
    logic [POL_ADDR_W-1:0]   w_pol_rd_addr;
    logic [TRANS_ADDR_W-1:0] w_sw_trans_addr;
    logic [COST_ADDR_W-1:0]  w_sw_cost_addr_a;
    logic [COST_ADDR_W-1:0]  w_sw_cost_addr_b;
    t_cost_wr                w_sw_cost_wr;
    t_pol_wr                 w_sw_pol_wr;
    logic                    w_sweep_busy;
    logic                    w_sweep_done;
    logic                    w_qry_seen;

    // input beat unpack
    always_comb begin
        w_in_item.kind       = t_kind'(i_s_axis_tuser);
        w_in_item.state_idx  = i_s_axis_tdata[9:0];
        w_in_item.input_idx  = i_s_axis_tdata[13:10];
        w_in_item.next_state = i_s_axis_tdata[23:14];
        w_in_item.cost       = i_s_axis_tdata[55:24];
        w_in_item.stage      = i_s_axis_tdata[61:56];
    end

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free = !r_m_valid || i_m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states_use <= NS_W'(MAX_STATES);
            r_inputs_use <= NU_W'(MAX_INPUTS);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STATES: r_states_use <= i_cfg_wdata;
                CFG_INPUTS: r_inputs_use <= i_cfg_wdata[NU_W-1:0];
                default:    r_states_use <= r_states_use;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_in_item.kind)
                        KIND_TERM, KIND_TRANS: n_state = ST_LOAD;
                        KIND_BACKUP:           n_state = ST_SWEEP;
                        KIND_QUERY:            n_state = ST_QREAD;
                        default:               n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:  n_state = ST_RESP;
            ST_SWEEP: begin
                if (w_sweep_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_QREAD: n_state = ST_QRESP;
            ST_QRESP, ST_RESP: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs: handshake, memory port muxing
    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        w_res_load      = (r_state == ST_RESP) || (r_state == ST_QRESP);

        w_cost_wr = w_sw_cost_wr;
        if (r_state == ST_CLEAR) begin
            w_cost_wr.en   = 1'b1;
            w_cost_wr.addr = r_clr;
            w_cost_wr.data = COST_INF;
        end else if (r_state == ST_LOAD && r_item.kind == KIND_TERM) begin
            w_cost_wr.en   = 1'b1;
            w_cost_wr.addr = {r_bank, r_item.state_idx};
            w_cost_wr.data = r_item.cost;
        end

        w_trans_wr.en              = (r_state == ST_LOAD) && (r_item.kind == KIND_TRANS);
        w_trans_wr.addr            = {r_item.input_idx, r_item.state_idx};
        w_trans_wr.data.next       = r_item.next_state;
        w_trans_wr.data.cost       = r_item.cost;

        w_cost_rd_addr_a = (r_state == ST_SWEEP) ? w_sw_cost_addr_a
                                                 : {r_bank, r_item.state_idx};
        w_pol_rd_addr    = {r_item.stage, r_item.state_idx};
    end

    // item capture, sweep kick-off, clearing pass
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_start <= w_accept && (w_in_item.kind == KIND_BACKUP);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + COST_ADDR_W'(1);
            end
        end
    end

    // bank flip and written-stage marks at the end of a backup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank       <= 1'b0;
            r_stage_seen <= '0;
        end else if (r_state == ST_SWEEP && w_sweep_done) begin
            r_bank                     <= ~r_bank;
            r_stage_seen[r_item.stage] <= 1'b1;
        end
    end

    // result register
    assign w_qry_seen = r_stage_seen[r_item.stage];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_m_valid <= w_res_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_res_load) begin
            if (r_state == ST_QRESP) begin
                r_m_data <= {1'b0,
                             (w_cost_rd_a == COST_INF),
                             (w_qry_seen ? w_pol_rd.inp : INPUT_W'(0)),
                             (w_qry_seen ? w_pol_rd.next : STATE_W'(0)),
                             w_cost_rd_a};
                r_m_user <= 1'b0;
            end else begin
                r_m_data <= '0;
                r_m_user <= 1'b1;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    bbs_sweep u_sweep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (r_start),
        .i_bank           (r_bank),
        .i_ns             (r_states_use),
        .i_nu             (r_inputs_use),
        .i_stage          (r_item.stage),
        .i_stage_seen     (w_qry_seen),
        .i_trans_rd       (w_trans_rd),
        .i_cost_rd_a      (w_cost_rd_a),
        .i_cost_rd_b      (w_cost_rd_b),
        .o_trans_rd_addr  (w_sw_trans_addr),
        .o_cost_rd_addr_a (w_sw_cost_addr_a),
        .o_cost_rd_addr_b (w_sw_cost_addr_b),
        .o_cost_wr        (w_sw_cost_wr),
        .o_pol_wr         (w_sw_pol_wr),
        .o_busy           (w_sweep_busy),
        .o_done           (w_sweep_done)
    );

    bbs_store u_store (
        .i_clk            (i_clk),
        .i_cost_wr        (w_cost_wr),
        .i_cost_rd_addr_a (w_cost_rd_addr_a),
        .i_cost_rd_addr_b (w_sw_cost_addr_b),
        .o_cost_rd_a      (w_cost_rd_a),
        .o_cost_rd_b      (w_cost_rd_b),
        .i_trans_wr       (w_trans_wr),
        .i_trans_rd_addr  (w_sw_trans_addr),
        .o_trans_rd       (w_trans_rd),
        .i_pol_wr         (w_sw_pol_wr),
        .i_pol_rd_addr    (w_pol_rd_addr),
        .o_pol_rd         (w_pol_rd)
    );

    `BBS_ASSERT(a_sweep_in_state, i_clk, i_rst_n,
        w_sweep_busy |-> (r_state == ST_SWEEP), "sweep active outside backup")
    `BBS_ASSERT(a_no_wr_clash, i_clk, i_rst_n,
        ((r_state == ST_CLEAR) || (r_state == ST_LOAD)) |-> !w_sw_cost_wr.en,
        "cost write port contention")

endmodule

FILE: test/tb_top.sv
// Testbench for the tabled backward Bellman sweep core: predicted results vs. the result stream.
`timescale 1ns / 100ps
module tb_top
    import bbs_pkg::*;
();

    localparam int LIMIT_CYCLES = 2_000_000;

    // One result beat split into its fields
    typedef struct packed {
        t_cost              cost;
        logic [STATE_W-1:0] next;
        logic [INPUT_W-1:0] inp;
        logic               inf;
        logic               done;
    } t_sweep_answer;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    t_item         cur_item = '0;
    t_item         sweep_cmds[$];
    t_sweep_answer awaited_answers[$];
    int unsigned   send_gap = 0;
    int unsigned   recv_gap = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   fail_count = 0;

    // Predictor state
    t_cost              cost_mem[2][MAX_STATES];
    logic               cur_bank;
    logic [STATE_W-1:0] trans_next[MAX_INPUTS][MAX_STATES];
    t_cost              trans_cost[MAX_INPUTS][MAX_STATES];
    logic [STATE_W-1:0] plan_next[MAX_STAGES][MAX_STATES];
    logic [INPUT_W-1:0] plan_input[MAX_STAGES][MAX_STATES];
    int unsigned        states_cfg;
    int unsigned        inputs_cfg;

    // Stimulus bookkeeping
    bit          trans_loaded[MAX_INPUTS][MAX_STATES];
    int unsigned used_stages[$];

    assign s_tdata = {2'b00, cur_item.stage, cur_item.cost, cur_item.next_state,
                      cur_item.input_idx, cur_item.state_idx};
    assign s_tuser = cur_item.kind;

    tabled_bellman_backward_sweep_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Saturating cost sum: infinity in or a sum reaching all ones gives infinity
    function automatic t_cost cost_sum(input t_cost a, input t_cost b);
        logic [COST_W:0] s;
        if (a == COST_INF || b == COST_INF) return COST_INF;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, COST_INF}) ? COST_INF : s[COST_W-1:0];
    endfunction

    // Apply one item to the predictor and return the answer it should give
    function automatic t_sweep_answer apply_sweep_item(input t_item it);
        t_sweep_answer      r;
        int unsigned        ns;
        int unsigned        nu;
        t_cost              best;
        t_cost              cand;
        logic [STATE_W-1:0] bn;
        logic [INPUT_W-1:0] bi;
        logic [STATE_W-1:0] nx;
        bit                 found;
        r = '0;
        case (it.kind)
            KIND_TERM: begin
                cost_mem[cur_bank][it.state_idx] = it.cost;
                r.done = 1'b1;
            end
            KIND_TRANS: begin
                trans_next[it.input_idx][it.state_idx] = it.next_state;
                trans_cost[it.input_idx][it.state_idx] = it.cost;
                r.done = 1'b1;
            end
            KIND_BACKUP: begin
                ns = (states_cfg > MAX_STATES) ? MAX_STATES : states_cfg;
                nu = (inputs_cfg > MAX_INPUTS) ? MAX_INPUTS : inputs_cfg;
                for (int s = 0; s < MAX_STATES; s++) begin
                    if (s >= ns) begin
                        cost_mem[cur_bank ^ 1'b1][s] = cost_mem[cur_bank][s];
                    end else begin
                        best  = COST_INF;
                        bn    = '0;
                        bi    = '0;
                        found = 0;
                        // first strictly lower candidate wins, ties keep the earlier input
                        for (int u = 0; u < nu; u++) begin
                            nx = trans_next[u][s];
                            if (nx < ns) begin
                                cand = cost_sum(trans_cost[u][s], cost_mem[cur_bank][nx]);
                                if (cand < best) begin
                                    best  = cand;
                                    bn    = nx;
                                    bi    = u[INPUT_W-1:0];
                                    found = 1;
                                end
                            end
                        end
                        cost_mem[cur_bank ^ 1'b1][s] = found ? best : cost_mem[cur_bank][s];
                        plan_next[it.stage][s]  = found ? bn : '0;
                        plan_input[it.stage][s] = found ? bi : '0;
                    end
                end
                cur_bank = cur_bank ^ 1'b1;
                r.done = 1'b1;
            end
            default: begin
                r.cost = cost_mem[cur_bank][it.state_idx];
                r.inf  = (r.cost == COST_INF);
                r.next = plan_next[it.stage][it.state_idx];
                r.inp  = plan_input[it.stage][it.state_idx];
            end
        endcase
        return r;
    endfunction

    // No gap unless a draw falls below pct; of the gaps most are short and a few long
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(99, 0) >= pct) return 0;
        if ($urandom_range(19, 0) == 0) return $urandom_range(60, 20);
        return $urandom_range(3, 1);
    endfunction

    task automatic report_bad(input string what, input logic [63:0] want,
                              input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // Input driver: one beat per queued item, random gap after each beat
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (sweep_cmds.size() != 0) begin
                cur_item <= sweep_cmds.pop_front();
                s_valid  <= 1'b1;
                send_gap <= pick_gap(send_idle_pct);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: may stall after a taken beat
    always @(posedge clk) begin : rx_stall
        int unsigned g;
        if (!rst_n) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            m_ready  <= (recv_gap == 1);
        end else if (m_valid && m_ready) begin
            g = pick_gap(recv_idle_pct);
            recv_gap <= g;
            m_ready  <= (g == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on accepted input beats, check accepted result beats
    always @(posedge clk) begin : result_check
        t_sweep_answer want;
        t_sweep_answer got;
        if (rst_n) begin
            if (s_valid && s_ready)
                awaited_answers.push_back(apply_sweep_item(cur_item));
            if (m_valid && m_ready) begin
                got.cost = m_tdata[31:0];
                got.next = m_tdata[41:32];
                got.inp  = m_tdata[45:42];
                got.inf  = m_tdata[46];
                got.done = m_tuser;
                if (awaited_answers.size() == 0) begin
                    report_bad("unexpected beat", '0, 64'(m_tdata));
                end else begin
                    want = awaited_answers.pop_front();
                    if (got.cost !== want.cost)
                        report_bad("cost", 64'(want.cost), 64'(got.cost));
                    if (got.next !== want.next)
                        report_bad("best_next", 64'(want.next), 64'(got.next));
                    if (got.inp !== want.inp)
                        report_bad("best_input", 64'(want.inp), 64'(got.inp));
                    if (got.inf !== want.inf)
                        report_bad("is_infinite", 64'(want.inf), 64'(got.inf));
                    if (got.done !== want.done)
                        report_bad("done_res", 64'(want.done), 64'(got.done));
                end
            end
        end
    end

    task automatic queue_item(input t_kind k, input int unsigned si, input int unsigned ui,
                              input int unsigned nx, input t_cost c, input int unsigned stg);
        t_item it;
        it.kind       = k;
        it.state_idx  = si[STATE_W-1:0];
        it.input_idx  = ui[INPUT_W-1:0];
        it.next_state = nx[STATE_W-1:0];
        it.cost       = c;
        it.stage      = stg[STAGE_W-1:0];
        if (k == KIND_TRANS) trans_loaded[it.input_idx][it.state_idx] = 1;
        if (k == KIND_BACKUP) used_stages.push_back(stg);
        sweep_cmds.push_back(it);
    endtask

    function automatic t_cost rand_cost();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return COST_INF;
            2:       return COST_INF - 1;
            3:       return COST_INF - $urandom_range(200, 1);
            4, 5:    return $urandom;
            default: return $urandom_range(1000, 0);
        endcase
    endfunction

    // Mostly a state in use, now and then any state
    function automatic int unsigned pick_state(input int unsigned ns);
        if (ns != 0 && $urandom_range(3, 0) != 0) return $urandom_range(ns - 1, 0);
        return $urandom_range(MAX_STATES - 1, 0);
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_STATES) states_cfg = val & 11'h7FF;
        else inputs_cfg = val & 5'h1F;
    endtask

    // Wait until every item is sent and every answer has come
    task automatic settle();
        while (sweep_cmds.size() != 0 || s_valid || awaited_answers.size() != 0) begin
            @(posedge clk);
            #1;
        end
        repeat (4) @(posedge clk);
    endtask

    // One setting of the counts: cover the transition table it reads, then random items
    task automatic run_phase(input int unsigned ns_w, input int unsigned nu_w,
                             input int unsigned n_items, input int unsigned idle);
        int unsigned ns;
        int unsigned nu;
        int unsigned pick;
        int unsigned stg;
        send_idle_pct = idle;
        recv_idle_pct = idle;
        write_reg(CFG_STATES, ns_w);
        write_reg(CFG_INPUTS, nu_w);
        ns = (states_cfg > MAX_STATES) ? MAX_STATES : states_cfg;
        nu = (inputs_cfg > MAX_INPUTS) ? MAX_INPUTS : inputs_cfg;
        for (int u = 0; u < nu; u++)
            for (int s = 0; s < ns; s++)
                if (!trans_loaded[u][s])
                    queue_item(KIND_TRANS, s, u, pick_state(ns), rand_cost(), 0);
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99, 0);
            if (pick < 15) begin
                queue_item(KIND_TERM, pick_state(ns), $urandom_range(15, 0),
                           $urandom_range(1023, 0), rand_cost(), $urandom_range(63, 0));
            end else if (pick < 35) begin
                queue_item(KIND_TRANS, pick_state(ns),
                           (nu != 0 && $urandom_range(2, 0) != 0) ? $urandom_range(nu - 1, 0)
                                                                  : $urandom_range(15, 0),
                           pick_state(ns), rand_cost(), $urandom_range(63, 0));
            end else if (pick < 55) begin
                queue_item(KIND_BACKUP, $urandom_range(1023, 0), $urandom_range(15, 0),
                           $urandom_range(1023, 0), $urandom, $urandom_range(63, 0));
            end else begin
                if (used_stages.size() != 0 && $urandom_range(4, 0) < 3)
                    stg = used_stages[$urandom_range(used_stages.size() - 1, 0)];
                else
                    stg = $urandom_range(63, 0);
                queue_item(KIND_QUERY, pick_state(ns), $urandom_range(15, 0),
                           $urandom_range(1023, 0), $urandom, stg);
            end
        end
        settle();
    endtask

    // Run time limit
    initial begin
        #(64'd8 * LIMIT_CYCLES);
        $display("tabled_bellman_backward_sweep_core test failed");
        $finish;
    end

    initial begin
        // predictor state after reset
        for (int s = 0; s < MAX_STATES; s++) begin
            cost_mem[0][s] = COST_INF;
            cost_mem[1][s] = COST_INF;
            for (int u = 0; u < MAX_INPUTS; u++) begin
                trans_next[u][s]   = '0;
                trans_cost[u][s]   = '0;
                trans_loaded[u][s] = 0;
            end
            for (int g = 0; g < MAX_STAGES; g++) begin
                plan_next[g][s]  = '0;
                plan_input[g][s] = '0;
            end
        end
        cur_bank   = 1'b0;
        states_cfg = MAX_STATES;
        inputs_cfg = MAX_INPUTS;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: four states, two inputs
        write_reg(CFG_STATES, 4);
        write_reg(CFG_INPUTS, 2);
        queue_item(KIND_QUERY, 0, 0, 0, '0, 0);
        queue_item(KIND_QUERY, 1023, 15, 1023, COST_INF, 63);
        queue_item(KIND_TERM, 0, 0, 0, '0, 0);
        queue_item(KIND_TERM, 1, 0, 0, COST_INF - 1, 0);
        queue_item(KIND_TERM, 2, 0, 0, 5, 0);
        queue_item(KIND_TERM, 3, 0, 0, COST_INF, 0);
        queue_item(KIND_TERM, 1023, 0, 0, 7, 0);
        // state 0: input 0 saturates to infinity, input 1 wins
        queue_item(KIND_TRANS, 0, 0, 1, 1, 0);
        queue_item(KIND_TRANS, 0, 1, 2, 3, 0);
        // state 1: equal sums, first input kept
        queue_item(KIND_TRANS, 1, 0, 0, 10, 0);
        queue_item(KIND_TRANS, 1, 1, 2, 5, 0);
        // state 2: successor out of use and infinite successor, no finite candidate
        queue_item(KIND_TRANS, 2, 0, 1023, 0, 0);
        queue_item(KIND_TRANS, 2, 1, 3, 0, 0);
        // state 3: infinite stage cost, then a largest finite sum
        queue_item(KIND_TRANS, 3, 0, 2, COST_INF, 0);
        queue_item(KIND_TRANS, 3, 1, 0, COST_INF - 1, 0);
        queue_item(KIND_BACKUP, 0, 0, 0, '0, 0);
        for (int s = 0; s < 4; s++) queue_item(KIND_QUERY, s, 0, 0, '0, 0);
        queue_item(KIND_BACKUP, 1023, 15, 1023, COST_INF, 63);
        queue_item(KIND_QUERY, 1023, 0, 0, '0, 63);
        queue_item(KIND_QUERY, 2, 0, 0, '0, 63);
        settle();

        // Extremes of the counts, zero and saturating values among them
        run_phase(0, 0, 6, 30);
        run_phase(6, 1, 10, 20);
        run_phase(2047, 0, 6, 40);
        run_phase(1, 31, 10, 50);
        run_phase(2, 3, 8, 0);

        // Random small grids
        for (int p = 0; p < 3; p++)
            run_phase($urandom_range(6, 1), $urandom_range(3, 1), 6,
                      (p == 0) ? 0 : $urandom_range(80, 10));

        repeat (50) @(posedge clk);
        if (fail_count == 0 && awaited_answers.size() == 0)
            $display("tabled_bellman_backward_sweep_core test passed");
        else
            $display("tabled_bellman_backward_sweep_core test failed");
        $finish;
    end

endmodule

FILE: tabled_bellman_backward_sweep_core.f
+incdir+design
design/bbs_pkg.sv
design/bbs_store.sv
design/bbs_sweep.sv
design/tabled_bellman_backward_sweep_core.sv
test/tb_top.sv
